// ===== hdl/line_pixel_rasterizer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// line pixel rasterizer assertion macros
// shared checks on the clock and synchronous reset of the rasterizer
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_RASTERIZER_UNIT_DEFINES_SVH
`define LINE_PIXEL_RASTERIZER_UNIT_DEFINES_SVH

// condition holds in the same cycle
`define LPR_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the following cycle
`define LPR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// line pixel rasterizer package
// shared constants and codes of the line rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEFAULT = 10;

   // width of an rgb565 color
   localparam int COLOR_BITS = 16;

   // request kind carried in tuser
   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

   // per-axis step direction
   typedef enum logic [1:0] {
      DIR_NONE  = 2'd0,
      DIR_PLUS  = 2'd1,
      DIR_MINUS = 2'd3
   } dir_type;

endpackage

`default_nettype wire

// ===== hdl/line_pixel_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// line pixel rasterizer unit
// error-accumulator line walk emitting one pixel per step request
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser holds the kind (start or step), tdata the two
//   endpoints and the color. A start request loads a new line and gives no
//   pixel; it also abandons any line still in progress. Each step request
//   while a line is active gives one pixel on the rsp channel, tlast marks
//   the final pixel; a line of major length L gives L + 1 pixels. A step
//   with no active line is consumed and gives nothing.
//   Each pixel is registered into the output register or the skid entry.
//   Throughput: one request per cycle while req_tready is high; the position
//   and error registers update in the same cycle as the request, so
//   back-to-back steps run at one pixel per clock unless the receiver stalls.
//   The rsp side has an output register plus one skid entry; when the
//   receiver stalls, one more pixel still goes into the skid entry, then
//   req_tready drops until the skid entry moves up to the output register.
//   Reset (synchronous, active high) idles the walk and empties both the
//   output register and the skid entry.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_pixel_rasterizer_unit_defines.svh"

module line_pixel_rasterizer_unit #(
   parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   // request channel
   input  wire logic req_tvalid,
   output logic      req_tready,
   // x_start, y_start, x_end, y_end, color (lowest bit first), zero padded
   input  wire logic [((4*COORD_BITS+lpr_pkg::COLOR_BITS+7)/8)*8-1:0] req_tdata,
   // kind
   input  wire logic req_tuser,
   // response channel
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // pixel_x, pixel_y, pixel_color (lowest bit first), zero padded
   output logic [((2*COORD_BITS+lpr_pkg::COLOR_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic      rsp_tlast
);

   localparam int CB = COORD_BITS;
   localparam int CLR = lpr_pkg::COLOR_BITS;
   localparam int OUT_BITS = ((2*CB+CLR+7)/8)*8;

   // handshake
   logic accept;
   logic pop;
   logic is_start;
   logic emit;

   // unpacked request fields
   logic [CB-1:0]  x_start;
   logic [CB-1:0]  y_start;
   logic [CB-1:0]  x_end;
   logic [CB-1:0]  y_end;
   logic [CLR-1:0] color;

   // walk state
   logic [CB-1:0]       cur_col_ff, cur_col_in;
   logic [CB-1:0]       cur_row_ff, cur_row_in;
   logic [CB:0]         col_error_ff, col_error_in;
   logic [CB:0]         row_error_ff, row_error_in;
   logic [CB-1:0]       col_delta_ff, col_delta_in;
   logic [CB-1:0]       row_delta_ff, row_delta_in;
   logic [CB-1:0]       major_ff, major_in;
   lpr_pkg::dir_type    col_dir_ff, col_dir_in;
   lpr_pkg::dir_type    row_dir_ff, row_dir_in;
   logic [CB:0]         pixels_left_ff, pixels_left_in;
   logic [CLR-1:0]      line_color_ff, line_color_in;
   logic                busy_ff, busy_in;

   // step arithmetic
   logic [CB:0]   col_sum;
   logic [CB:0]   row_sum;
   logic [CB-1:0] col_moved;
   logic [CB-1:0] row_moved;
   logic          is_last;

   // new pixel
   logic [OUT_BITS-1:0] pix_data;

   // output register and skid entry
   logic                out_valid_ff, out_valid_in;
   logic [OUT_BITS-1:0] out_data_ff, out_data_in;
   logic                out_last_ff, out_last_in;
   logic                skid_valid_ff, skid_valid_in;
   logic [OUT_BITS-1:0] skid_data_ff, skid_data_in;
   logic                skid_last_ff, skid_last_in;

   // request unpacking
   assign x_start = req_tdata[CB-1:0];
   assign y_start = req_tdata[2*CB-1:CB];
   assign x_end   = req_tdata[3*CB-1:2*CB];
   assign y_end   = req_tdata[4*CB-1:3*CB];
   assign color   = req_tdata[4*CB+CLR-1:4*CB];

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign is_start   = (lpr_pkg::kind_type'(req_tuser) == lpr_pkg::KIND_START);
   assign emit       = accept && !is_start && busy_ff;
   assign is_last    = (pixels_left_ff <= (CB+1)'(1));

   // error accumulation sums
   assign col_sum = col_error_ff + {1'b0, col_delta_ff};
   assign row_sum = row_error_ff + {1'b0, row_delta_ff};

   // column move by direction
   always_comb begin
      unique case (col_dir_ff)
         lpr_pkg::DIR_PLUS:  col_moved = cur_col_ff + CB'(1);
         lpr_pkg::DIR_MINUS: col_moved = cur_col_ff - CB'(1);
         default:            col_moved = cur_col_ff;
      endcase
   end

   // row move by direction
   always_comb begin
      unique case (row_dir_ff)
         lpr_pkg::DIR_PLUS:  row_moved = cur_row_ff + CB'(1);
         lpr_pkg::DIR_MINUS: row_moved = cur_row_ff - CB'(1);
         default:            row_moved = cur_row_ff;
      endcase
   end

   // walk state next values
   always_comb begin
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      col_error_in   = col_error_ff;
      row_error_in   = row_error_ff;
      col_delta_in   = col_delta_ff;
      row_delta_in   = row_delta_ff;
      major_in       = major_ff;
      col_dir_in     = col_dir_ff;
      row_dir_in     = row_dir_ff;
      pixels_left_in = pixels_left_ff;
      line_color_in  = line_color_ff;
      busy_in        = busy_ff;
      if (accept && is_start) begin
         // column axis setup
         if (x_end > x_start) begin
            col_delta_in = x_end - x_start;
            col_dir_in   = lpr_pkg::DIR_PLUS;
         end else if (x_end < x_start) begin
            col_delta_in = x_start - x_end;
            col_dir_in   = lpr_pkg::DIR_MINUS;
         end else begin
            col_delta_in = '0;
            col_dir_in   = lpr_pkg::DIR_NONE;
         end
         // row axis setup
         if (y_end > y_start) begin
            row_delta_in = y_end - y_start;
            row_dir_in   = lpr_pkg::DIR_PLUS;
         end else if (y_end < y_start) begin
            row_delta_in = y_start - y_end;
            row_dir_in   = lpr_pkg::DIR_MINUS;
         end else begin
            row_delta_in = '0;
            row_dir_in   = lpr_pkg::DIR_NONE;
         end
         major_in       = (col_delta_in > row_delta_in) ? col_delta_in : row_delta_in;
         cur_col_in     = x_start;
         cur_row_in     = y_start;
         col_error_in   = '0;
         row_error_in   = '0;
         pixels_left_in = {1'b0, major_in} + (CB+1)'(1);
         line_color_in  = color;
         busy_in        = 1'b1;
      end else if (emit) begin
         // advance each axis on strict overflow of the error
         col_error_in = col_sum;
         row_error_in = row_sum;
         if (col_sum > {1'b0, major_ff}) begin
            col_error_in = col_sum - {1'b0, major_ff};
            cur_col_in   = col_moved;
         end
         if (row_sum > {1'b0, major_ff}) begin
            row_error_in = row_sum - {1'b0, major_ff};
            cur_row_in   = row_moved;
         end
         if (is_last) begin
            pixels_left_in = '0;
            busy_in        = 1'b0;
         end else begin
            pixels_left_in = pixels_left_ff - (CB+1)'(1);
         end
      end
   end

   // pixel packing
   always_comb begin
      pix_data                   = '0;
      pix_data[CB-1:0]           = cur_col_ff;
      pix_data[2*CB-1:CB]        = cur_row_ff;
      pix_data[2*CB+CLR-1:2*CB]  = line_color_ff;
   end

   // output register and skid entry next values
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      skid_last_in  = skid_last_ff;
      if (pop) begin
         out_valid_in = 1'b0;
      end
      if (skid_valid_ff && pop) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         out_last_in   = skid_last_ff;
         skid_valid_in = 1'b0;
      end else if (emit) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = pix_data;
            out_last_in  = is_last;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = pix_data;
            skid_last_in  = is_last;
         end
      end
   end

   // control and walk registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         col_error_ff   <= '0;
         row_error_ff   <= '0;
         col_delta_ff   <= '0;
         row_delta_ff   <= '0;
         major_ff       <= '0;
         col_dir_ff     <= lpr_pkg::DIR_NONE;
         row_dir_ff     <= lpr_pkg::DIR_NONE;
         pixels_left_ff <= '0;
         line_color_ff  <= '0;
         busy_ff        <= 1'b0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         cur_col_ff     <= cur_col_in;
         cur_row_ff     <= cur_row_in;
         col_error_ff   <= col_error_in;
         row_error_ff   <= row_error_in;
         col_delta_ff   <= col_delta_in;
         row_delta_ff   <= row_delta_in;
         major_ff       <= major_in;
         col_dir_ff     <= col_dir_in;
         row_dir_ff     <= row_dir_in;
         pixels_left_ff <= pixels_left_in;
         line_color_ff  <= line_color_in;
         busy_ff        <= busy_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   // pixel payload registers
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
      skid_data_ff <= skid_data_in;
      skid_last_ff <= skid_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   // checks
   `LPR_ASSERT_SAME(a_skid_behind_out, skid_valid_ff, out_valid_ff, "skid holds a pixel ahead of output")
   `LPR_ASSERT_SAME(a_idle_no_pixels, !busy_ff, pixels_left_ff == '0, "idle walk with pixels left")
   `LPR_ASSERT_SAME(a_busy_has_pixels, busy_ff, pixels_left_ff != '0, "active walk with no pixels left")
   `LPR_ASSERT_NEXT(a_last_ends_walk, emit && is_last, !busy_ff, "walk still active after last pixel")

endmodule

`default_nettype wire
